[rtl/core/hfmls_pkg.sv]
// Shared types, constants and arithmetic helpers of the HMM frame match scorer.
package hfmls_pkg;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [16:0] HALF_Q16 = 17'h08000;
    localparam int LN2_Q16 = 45426;
    localparam logic signed [31:0] LN_ZERO = -32'sd726816;
    localparam logic signed [39:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] SUM_MIN = 40'sh80_0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_STAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_MATCH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_OCC = 2'd3;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_PROD   = 12'b0000_0000_0010,
        ST_WMIX1  = 12'b0000_0000_0100,
        ST_WMIX0  = 12'b0000_0000_1000,
        ST_WMUL   = 12'b0000_0001_0000,
        ST_ALIGN  = 12'b0000_0010_0000,
        ST_DIV    = 12'b0000_0100_0000,
        ST_LNPASS = 12'b0000_1000_0000,
        ST_TRANS  = 12'b0001_0000_0000,
        ST_UPD    = 12'b0010_0000_0000,
        ST_FIN1   = 12'b0100_0000_0000,
        ST_FIN2   = 12'b1000_0000_0000
    } state_t;

    // Likelihood product: mantissa times 2^-(16+sh).
    typedef struct packed {
        logic [16:0] m;
        logic [9:0]  sh;
    } smul_t;

    function automatic logic [15:0] ln_frac(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd3973;
            5'd2:  v = 16'd7719;
            5'd3:  v = 16'd11262;
            5'd4:  v = 16'd14624;
            5'd5:  v = 16'd17821;
            5'd6:  v = 16'd20870;
            5'd7:  v = 16'd23783;
            5'd8:  v = 16'd26573;
            5'd9:  v = 16'd29248;
            5'd10: v = 16'd31818;
            5'd11: v = 16'd34292;
            5'd12: v = 16'd36675;
            5'd13: v = 16'd38975;
            5'd14: v = 16'd41196;
            5'd15: v = 16'd43345;
            5'd16: v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Natural log of a Q1.16 value, clamped to one, interpolated between table points.
    function automatic logic signed [31:0] ln_q16(input logic [16:0] x);
        logic [16:0] xc;
        logic [4:0]  e;
        logic [4:0]  sh;
        logic [16:0] m;
        logic [3:0]  idx;
        logic [11:0] rem;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [27:0] ip;
        logic [16:0] val;
        logic [21:0] off;
        xc = (x > ONE_Q16) ? ONE_Q16 : x;
        e = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (xc[i]) e = 5'(i);
        end
        sh = 5'd16 - e;
        m = xc << sh;
        idx = m[15:12];
        rem = m[11:0];
        lo = ln_frac({1'b0, idx});
        hi = ln_frac({1'b0, idx} + 5'd1);
        ip = 28'(hi - lo) * 28'(rem) + 28'd2048;
        val = 17'(lo) + 17'(ip[27:12]);
        off = 22'(sh) * 22'(LN2_Q16);
        if (x == 17'd0) return LN_ZERO;
        return $signed(32'(val)) - $signed(32'(off));
    endfunction

    // One factor of a likelihood product, renormalised to [32768, 65536] or zero.
    function automatic smul_t scaled_mul(input smul_t s, input logic [16:0] p);
        logic [34:0] t;
        logic [16:0] r;
        logic [4:0]  n;
        smul_t       o;
        t = 35'(s.m) * 35'(p) + 35'd32768;
        r = t[32:16];
        n = 5'd0;
        if (r != 17'd0 && r < HALF_Q16) begin
            for (int i = 0; i < 16; i++) begin
                if (r[i]) n = 5'(15 - i);
            end
        end
        o.m = r << n;
        o.sh = s.sh + 10'(n);
        return o;
    endfunction

    // Two-way mixture u*y + v*(1-y), rounded.
    function automatic logic [16:0] mix(input logic [16:0] u, input logic [16:0] v,
                                        input logic [15:0] y);
        logic [35:0] t;
        t = 36'(u) * 36'(y) + 36'(v) * 36'(ONE_Q16 - 17'(y)) + 36'd32768;
        return t[32:16];
    endfunction

    function automatic logic signed [39:0] sat_add40(input logic signed [39:0] s,
                                                     input logic signed [31:0] v);
        logic signed [40:0] t;
        t = 41'(s) + 41'(v);
        if (t > 41'(SUM_MAX)) return SUM_MAX;
        if (t < 41'(SUM_MIN)) return SUM_MIN;
        return t[39:0];
    endfunction

endpackage

[rtl/core/hfmls_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module hfmls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/hmm_frame_match_llr_scorer.sv]
// Top level of the two-state HMM fingerprint frame match log-likelihood scorer.
// A table load beat is taken while idle and leaves the scorer ready. A frame makes a product
// pass through the flip table memory, one entry a cycle, then runs the radix-2 posterior
// divider unless both likelihoods vanish; a frame that does not open a run makes a second pass
// for its log terms, and a last frame ends with the final score. One item is in flight at a time.
// Reset is synchronous and active low: it clears the run state and restores the register
// defaults; the flip tables are undefined until they are loaded.
module hmm_frame_match_llr_scorer #(
    parameter int BITS_PER_FRAME   = 32,
    parameter int FRAME_COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [hfmls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hfmls_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // table_index[4:0], match_flip_prob[20:5], occluded_flip_prob[36:21],
    // distance_word[68:37], zero padding above
    input  logic [hfmls_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0]: 0 is a table load, 1 is a frame
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // score[31:0], frames_scored[47:32]
    output logic [hfmls_pkg::M_TDATA_W-1:0]   m_tdata
);
    import hfmls_pkg::*;

    localparam int AW  = (BITS_PER_FRAME > 1) ? $clog2(BITS_PER_FRAME) : 1;
    localparam int CW  = AW + 1;
    localparam int FCB = FRAME_COUNT_BITS;
    localparam logic [21:0] LN_BITS = 22'(BITS_PER_FRAME * LN2_Q16);
    localparam logic [CW-1:0] ISS_END = CW'(BITS_PER_FRAME);
    localparam logic [CW-1:0] ISS_LAST = CW'(BITS_PER_FRAME - 1);
    localparam logic [FCB-1:0] CNT_MAX = '1;

    // Input beat fields.
    logic [4:0]  in_index;
    logic [15:0] in_match;
    logic [15:0] in_occ;
    logic [31:0] in_word;
    assign in_index = s_tdata[4:0];
    assign in_match = s_tdata[20:5];
    assign in_occ   = s_tdata[36:21];
    assign in_word  = s_tdata[68:37];

    state_t state_reg, state_next;
    logic [15:0] stay_reg, stay_next, enter_reg, enter_next;
    logic [15:0] pm_reg, pm_next, po_reg, po_next;
    logic [15:0] post_reg, post_next;
    logic signed [39:0] bsum_reg, bsum_next, tsum_reg, tsum_next;
    logic [FCB-1:0] cnt_reg, cnt_next;
    logic in_run_reg, in_run_next;
    logic [BITS_PER_FRAME-1:0] word_reg, word_next;
    logic last_reg, last_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic vld1_reg, vld1_next, last1_reg, last1_next;
    logic [AW-1:0] bit1_reg, bit1_next;
    logic vld2_reg, vld2_next, last2_reg, last2_next;
    logic [16:0] xr_reg, xr_next;
    smul_t p1_reg, p1_next, p0_reg, p0_next;
    logic [16:0] w1_reg, w1_next, w0_reg, w0_next;
    logic signed [31:0] fsum_reg, fsum_next;
    logic [18:0] rem_reg, rem_next;
    logic [16:0] nlo_reg, nlo_next;
    logic [17:0] den_reg, den_next;
    logic [16:0] q_reg, q_next;
    logic [4:0] dcnt_reg, dcnt_next;
    logic [15:0] y_reg, y_next;
    logic [FCB+21:0] prod_reg, prod_next;
    logic m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Flip table memory: match probability low, occlusion probability high.
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_rdata;
    logic [AW+4:0] idx_ext;
    logic [BITS_PER_FRAME+31:0] word_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign idx_ext   = (AW + 5)'(in_index);
    assign ram_waddr = idx_ext[AW-1:0];
    assign ram_we    = s_tvalid && s_tready && !s_tuser[0] && (idx_ext < (AW + 5)'(BITS_PER_FRAME));
    assign ram_raddr = iss_reg[AW-1:0];
    assign word_ext  = (BITS_PER_FRAME + 32)'(in_word);

    hfmls_ram #(.WIDTH(32), .DEPTH(BITS_PER_FRAME)) u_flip_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_occ, in_match}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Per-bit factors of the entry that has just come out of the memory.
    logic flip;
    logic [16:0] f1, f0;
    assign flip = word_reg[bit1_reg];
    assign f1 = flip ? {1'b0, ram_rdata[15:0]}  : ONE_Q16 - {1'b0, ram_rdata[15:0]};
    assign f0 = flip ? {1'b0, ram_rdata[31:16]} : ONE_Q16 - {1'b0, ram_rdata[31:16]};

    // Shared mixture unit.
    logic [16:0] mu_u, mu_v, mu_out;
    logic [15:0] mu_y;
    always_comb begin
        mu_u = '0;
        mu_v = '0;
        mu_y = y_reg;
        case (state_reg)
            ST_WMIX1: begin
                mu_u = {1'b0, stay_reg};
                mu_v = {1'b0, enter_reg};
                mu_y = post_reg;
            end
            ST_WMIX0: begin
                mu_u = ONE_Q16 - {1'b0, stay_reg};
                mu_v = ONE_Q16 - {1'b0, enter_reg};
                mu_y = post_reg;
            end
            ST_LNPASS: begin
                mu_u = f1;
                mu_v = f0;
            end
            ST_TRANS: begin
                mu_u = w1_reg;
                mu_v = ONE_Q16 - w1_reg;
            end
            default: begin
                mu_u = '0;
                mu_v = '0;
            end
        endcase
    end
    assign mu_out = mix(mu_u, mu_v, mu_y);

    // Shared log unit works on the registered mixture.
    logic signed [31:0] ln_out;
    assign ln_out = ln_q16(xr_reg);

    // Two product units, one per class.
    smul_t sm1, sm0;
    assign sm1 = scaled_mul(p1_reg, (state_reg == ST_WMUL) ? w1_reg : f1);
    assign sm0 = scaled_mul(p0_reg, (state_reg == ST_WMUL) ? w0_reg : f0);

    // Exponent alignment ahead of the posterior division.
    logic [16:0] am, bm;
    logic [17:0] den;
    logic [33:0] num;
    always_comb begin
        am = p1_reg.m;
        bm = p0_reg.m;
        if (p1_reg.sh > p0_reg.sh) am = p1_reg.m >> (p1_reg.sh - p0_reg.sh);
        else if (p0_reg.sh > p1_reg.sh) bm = p0_reg.m >> (p0_reg.sh - p1_reg.sh);
        den = 18'(am) + 18'(bm);
        num = {1'b0, am, 16'd0} + 34'(den >> 1);
    end

    // One quotient bit per cycle.
    logic [18:0] div_r2;
    logic div_ge;
    assign div_r2 = {rem_reg[17:0], nlo_reg[16]};
    assign div_ge = (div_r2 >= {1'b0, den_reg});

    // Final score, saturated to 32 bits.
    logic signed [49:0] total;
    logic [FCB+15:0] cnt_ext;
    logic [31:0] score;
    logic [15:0] frames;
    assign total = 50'(bsum_reg) + 50'(tsum_reg) + $signed(50'(prod_reg));
    assign cnt_ext = (FCB + 16)'(cnt_reg);
    assign frames = (cnt_ext > (FCB + 16)'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
    always_comb begin
        if (total > 50'sd2147483647) score = 32'h7FFF_FFFF;
        else if (total < -50'sd2147483648) score = 32'h8000_0000;
        else score = total[31:0];
    end

    always_comb begin
        state_next   = state_reg;
        stay_next    = stay_reg;
        enter_next   = enter_reg;
        pm_next      = pm_reg;
        po_next      = po_reg;
        post_next    = post_reg;
        bsum_next    = bsum_reg;
        tsum_next    = tsum_reg;
        cnt_next     = cnt_reg;
        in_run_next  = in_run_reg;
        word_next    = word_reg;
        last_next    = last_reg;
        iss_next     = iss_reg;
        vld1_next    = 1'b0;
        last1_next   = last1_reg;
        bit1_next    = bit1_reg;
        vld2_next    = 1'b0;
        last2_next   = last2_reg;
        xr_next      = xr_reg;
        p1_next      = p1_reg;
        p0_next      = p0_reg;
        w1_next      = w1_reg;
        w0_next      = w0_reg;
        fsum_next    = fsum_reg;
        rem_next     = rem_reg;
        nlo_next     = nlo_reg;
        den_next     = den_reg;
        q_next       = q_reg;
        dcnt_next    = dcnt_reg;
        y_next       = y_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STAY:        stay_next  = cfg_wdata;
                CFG_ENTER:       enter_next = cfg_wdata;
                CFG_PRIOR_MATCH: pm_next    = cfg_wdata;
                CFG_PRIOR_OCC:   po_next    = cfg_wdata;
                default:         stay_next  = stay_reg;
            endcase
        end

        // The memory pass issues one address a cycle in both pass states.
        if ((state_reg == ST_PROD || state_reg == ST_LNPASS) && iss_reg < ISS_END) begin
            iss_next   = iss_reg + CW'(1);
            vld1_next  = 1'b1;
            bit1_next  = iss_reg[AW-1:0];
            last1_next = (iss_reg == ISS_LAST);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser[0]) begin
                    word_next  = word_ext[BITS_PER_FRAME-1:0];
                    last_next  = s_tlast;
                    iss_next   = '0;
                    p1_next    = '{m: ONE_Q16, sh: 10'd0};
                    p0_next    = '{m: ONE_Q16, sh: 10'd0};
                    fsum_next  = '0;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                if (vld1_reg) begin
                    p1_next = sm1;
                    p0_next = sm0;
                    if (last1_reg) state_next = ST_WMIX1;
                end
            end
            ST_WMIX1: begin
                w1_next    = in_run_reg ? mu_out : {1'b0, pm_reg};
                state_next = ST_WMIX0;
            end
            ST_WMIX0: begin
                w0_next    = in_run_reg ? mu_out : {1'b0, po_reg};
                state_next = ST_WMUL;
            end
            ST_WMUL: begin
                p1_next    = sm1;
                p0_next    = sm0;
                state_next = ST_ALIGN;
            end
            ST_ALIGN: begin
                den_next  = den;
                rem_next  = 19'(num[33:17]);
                nlo_next  = num[16:0];
                q_next    = '0;
                dcnt_next = '0;
                iss_next  = '0;
                if (den == 18'd0) begin
                    // Both likelihoods vanished: the posterior falls back to one half.
                    y_next     = 16'h8000;
                    state_next = in_run_reg ? ST_LNPASS : ST_UPD;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? div_r2 - {1'b0, den_reg} : div_r2;
                nlo_next  = {nlo_reg[15:0], 1'b0};
                q_next    = {q_reg[15:0], div_ge};
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd16) begin
                    y_next     = q_reg[15] ? 16'hFFFF : {q_reg[14:0], div_ge};
                    state_next = in_run_reg ? ST_LNPASS : ST_UPD;
                end
            end
            ST_LNPASS: begin
                if (vld1_reg) begin
                    xr_next    = mu_out;
                    vld2_next  = 1'b1;
                    last2_next = last1_reg;
                end
                if (vld2_reg) begin
                    fsum_next = fsum_reg + ln_out;
                    if (last2_reg) state_next = ST_TRANS;
                end
            end
            ST_TRANS: begin
                xr_next    = mu_out;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (in_run_reg) begin
                    bsum_next = sat_add40(bsum_reg, fsum_reg);
                    tsum_next = sat_add40(tsum_reg, ln_out);
                end
                if (cnt_reg != CNT_MAX) cnt_next = cnt_reg + FCB'(1);
                post_next   = y_reg;
                in_run_next = 1'b1;
                state_next  = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                prod_next  = (FCB + 22)'(cnt_reg) * (FCB + 22)'(LN_BITS);
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {frames, score};
                    post_next    = '0;
                    bsum_next    = '0;
                    tsum_next    = '0;
                    cnt_next     = '0;
                    in_run_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stay_reg    <= '0;
            enter_reg   <= '0;
            pm_reg      <= 16'h8000;
            po_reg      <= 16'h8000;
            post_reg    <= '0;
            bsum_reg    <= '0;
            tsum_reg    <= '0;
            cnt_reg     <= '0;
            in_run_reg  <= 1'b0;
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stay_reg    <= stay_next;
            enter_reg   <= enter_next;
            pm_reg      <= pm_next;
            po_reg      <= po_next;
            post_reg    <= post_next;
            bsum_reg    <= bsum_next;
            tsum_reg    <= tsum_next;
            cnt_reg     <= cnt_next;
            in_run_reg  <= in_run_next;
            vld1_reg    <= vld1_next;
            vld2_reg    <= vld2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        last_reg   <= last_next;
        iss_reg    <= iss_next;
        last1_reg  <= last1_next;
        bit1_reg   <= bit1_next;
        last2_reg  <= last2_next;
        xr_reg     <= xr_next;
        p1_reg     <= p1_next;
        p0_reg     <= p0_next;
        w1_reg     <= w1_next;
        w0_reg     <= w0_next;
        fsum_reg   <= fsum_next;
        rem_reg    <= rem_next;
        nlo_reg    <= nlo_next;
        den_reg    <= den_next;
        q_reg      <= q_next;
        dcnt_reg   <= dcnt_next;
        y_reg      <= y_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end
endmodule

[rtl/core/hfmls_checker.sv]
// Port-level assertions for the HMM frame match scorer, bound to its top level.
module hfmls_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [0:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hfmls_pkg::M_TDATA_W-1:0] m_tdata
);
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat pending after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("frame beat did not occupy the scorer");

    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("table load beat took more than one cycle");

    a_frames_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:32] != 16'd0)
        else $error("result beat reports an empty run");
endmodule

bind hmm_frame_match_llr_scorer hfmls_checker u_hfmls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/hmm_frame_match_llr_scorer_tb.sv]
// Self-checking testbench for the two-state HMM frame match log-likelihood scorer.
module hmm_frame_match_llr_scorer_tb;

    import hfmls_pkg::*;

    // Points of ln(1 + i/16) in Q16.16, used by the scorer's own log approximation.
    localparam int LN_PTS [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                                   29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
    localparam int NBITS = 32;
    localparam int LN2_FIX = 45426;
    localparam longint ACC_MAX = 64'sd549755813887;
    localparam longint ACC_MIN = -64'sd549755813888;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 150;

    typedef struct {
        logic signed [31:0] score;
        logic [15:0]        frames;
    } run_score_t;

    // Likelihood product held as a mantissa in [32768, 65536] (or zero) and a shift.
    typedef struct {
        longint unsigned m;
        int unsigned     sh;
    } lik_t;

    // Tracks the filter state alongside the block and holds the scores still owed by it.
    class llr_scoreboard;
        int unsigned     stay_p, enter_p, prior_m, prior_o;
        int unsigned     match_tab [NBITS];
        int unsigned     occ_tab [NBITS];
        int unsigned     posterior;
        longint          bit_acc, trans_acc;
        int unsigned     frame_cnt;
        bit              running;
        run_score_t      owed_q [$];
        int              errors;

        function new();
            stay_p = 0;
            enter_p = 0;
            prior_m = 32768;
            prior_o = 32768;
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            posterior = 0;
            bit_acc = 0;
            trans_acc = 0;
            frame_cnt = 0;
            running = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
            case (idx)
                CFG_STAY:        stay_p = v;
                CFG_ENTER:       enter_p = v;
                CFG_PRIOR_MATCH: prior_m = v;
                CFG_PRIOR_OCC:   prior_o = v;
                default: ;
            endcase
        endfunction

        function int ln_fix(longint unsigned x);
            int              e;
            longint unsigned mm, frac, idx, rem;
            int              lo, hi;
            if (x == 0) return -16 * LN2_FIX;
            if (x > 65536) x = 65536;
            e = 16;
            while (((x >> e) & 1) == 0) e--;
            mm = x << (16 - e);
            frac = mm - 65536;
            idx = frac >> 12;
            rem = frac & 4095;
            lo = LN_PTS[idx];
            hi = LN_PTS[idx + 1];
            lo += int'((longint'(hi - lo) * rem + 2048) >> 12);
            return lo - (16 - e) * LN2_FIX;
        endfunction

        function lik_t lik_mul(lik_t s, longint unsigned p);
            s.m = (s.m * p + 32768) >> 16;
            while (s.m != 0 && s.m < 32768) begin
                s.m = s.m << 1;
                s.sh++;
            end
            return s;
        endfunction

        function longint unsigned blend(longint unsigned u, longint unsigned v,
                                        longint unsigned y);
            return (u * y + v * (65536 - y) + 32768) >> 16;
        endfunction

        function int unsigned match_share(lik_t a, lik_t b);
            longint unsigned am, bm, q;
            int unsigned     d;
            am = a.m;
            bm = b.m;
            if (a.sh > b.sh) begin
                d = a.sh - b.sh;
                am = (d >= 32) ? 0 : am >> d;
            end else if (b.sh > a.sh) begin
                d = b.sh - a.sh;
                bm = (d >= 32) ? 0 : bm >> d;
            end
            // Both classes impossible: fall back to an even split.
            if (am + bm == 0) return 32768;
            q = ((am << 16) + (am + bm) / 2) / (am + bm);
            return (q > 65535) ? 65535 : 32'(q);
        endfunction

        function longint acc40(longint s, longint v);
            s += v;
            if (s > ACC_MAX) s = ACC_MAX;
            if (s < ACC_MIN) s = ACC_MIN;
            return s;
        endfunction

        // Called for every beat the block accepts on its input side.
        function void note_beat(bit is_frame, logic [4:0] idx, logic [15:0] mp,
                                logic [15:0] op, logic [31:0] word, bit last);
            lik_t            l1, l0;
            longint unsigned w1, w0, f1, f0;
            int unsigned     y;
            longint          frame_sum, total;
            run_score_t      r;
            if (!is_frame) begin
                match_tab[idx] = 32'(mp);
                occ_tab[idx] = 32'(op);
                return;
            end
            l1.m = 65536; l1.sh = 0;
            l0.m = 65536; l0.sh = 0;
            for (int k = 0; k < NBITS; k++) begin
                l1 = lik_mul(l1, word[k] ? match_tab[k] : 65536 - match_tab[k]);
                l0 = lik_mul(l0, word[k] ? occ_tab[k] : 65536 - occ_tab[k]);
            end
            if (!running) begin
                w1 = prior_m;
                w0 = prior_o;
            end else begin
                w1 = blend(stay_p, enter_p, posterior);
                w0 = blend(65536 - stay_p, 65536 - enter_p, posterior);
            end
            l1 = lik_mul(l1, w1);
            l0 = lik_mul(l0, w0);
            y = match_share(l1, l0);
            if (running) begin
                frame_sum = 0;
                for (int k = 0; k < NBITS; k++) begin
                    f1 = word[k] ? match_tab[k] : 65536 - match_tab[k];
                    f0 = word[k] ? occ_tab[k] : 65536 - occ_tab[k];
                    frame_sum += ln_fix(blend(f1, f0, y));
                end
                bit_acc = acc40(bit_acc, frame_sum);
                trans_acc = acc40(trans_acc, ln_fix(blend(w1, 65536 - w1, y)));
            end
            if (frame_cnt < 65535) frame_cnt++;
            posterior = y;
            running = 1;
            if (!last) return;
            total = bit_acc + trans_acc + longint'(frame_cnt) * NBITS * LN2_FIX;
            if (total > 64'sd2147483647) total = 64'sd2147483647;
            if (total < -64'sd2147483648) total = -64'sd2147483648;
            r.score = total[31:0];
            r.frames = frame_cnt[15:0];
            owed_q.push_back(r);
            clear_run();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Called for every beat the block delivers on its result side.
        task check_beat(logic [M_TDATA_W-1:0] d);
            run_score_t r;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result beat %h", d));
                return;
            end
            r = owed_q.pop_front();
            if (d[31:0] !== r.score)
                report($sformatf("score %0d, expected %0d", $signed(d[31:0]), r.score));
            if (d[47:32] !== r.frames)
                report($sformatf("frames_scored %0d, expected %0d", d[47:32], r.frames));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [0:0]             s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    llr_scoreboard sb;
    bit            idle_en;     // random idling on both sides while set
    bit            hold_req;    // asks the receiver for one long hold-off
    int            hold_left;
    int            quiet_cycles;

    hmm_frame_match_llr_scorer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The receiver decides its ready at each falling edge. A requested hold-off keeps it
    // low long enough that the block backs up and stalls its input.
    initial begin
        bit hold_seen;
        m_tready = 1'b0;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = !(idle_en && $urandom_range(99) < 36);
            end
        end
    end

    // Result beats are checked at the rising edge at which they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    // The watchdog ends the run if neither side moves a beat for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high, so that
    // back-to-back beats keep tvalid asserted without a gap.
    task send_beat(bit is_frame, logic [4:0] idx, logic [15:0] mp, logic [15:0] op,
                   logic [31:0] word, bit last);
        while (idle_en && $urandom_range(99) < 36) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = is_frame;
        s_tlast = last;
        s_tdata = {3'b000, word, op, mp, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(is_frame, idx, mp, op, word, last);
        @(negedge aclk);
    endtask

    task load_entry(logic [4:0] idx, logic [15:0] mp, logic [15:0] op);
        send_beat(1'b0, idx, mp, op, $urandom, 1'($urandom_range(1)));
    endtask

    task send_frame(logic [31:0] word, bit last);
        send_beat(1'b1, 5'($urandom), 16'($urandom), 16'($urandom), word, last);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        sb.set_reg(idx, 32'(v));
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Registers may only change once the block has nothing in flight; a frame that is not
    // the last of its run leaves no result behind, hence the extra settling time.
    task wait_quiet();
        s_tvalid = 1'b0;
        while (sb.owed_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function logic [15:0] pick_prob();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(65535, 60000));
            3: return 16'($urandom_range(6000));
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return $urandom & $urandom & $urandom;
            1: return $urandom | $urandom;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed runs of frames with the odd table load mixed in, runs closed at
    // the end so that every frame of the phase contributes to a checked score.
    task random_phase(int n_beats);
        int run_left;
        run_left = 0;
        for (int i = 0; i < n_beats; i++) begin
            if ($urandom_range(99) < 8) begin
                load_entry(5'($urandom), pick_prob(), pick_prob());
            end else begin
                if (run_left == 0)
                    run_left = ($urandom_range(9) == 0) ? $urandom_range(40, 20)
                                                        : $urandom_range(1, 10);
                run_left--;
                send_frame(pick_word(), run_left == 0);
            end
        end
        if (run_left != 0) send_frame(pick_word(), 1'b1);
    endtask

    initial begin
        sb = new();
        idle_en = 1'b0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_STAY;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Every table entry is loaded before the first frame. The first four entries hold
        // the extremes: both zero, both one, and each class certain while the other is not.
        for (int k = 0; k < NBITS; k++) begin
            case (k)
                0: load_entry(5'(k), 16'd0, 16'd0);
                1: load_entry(5'(k), 16'hFFFF, 16'hFFFF);
                2: load_entry(5'(k), 16'd0, 16'hFFFF);
                3: load_entry(5'(k), 16'hFFFF, 16'd0);
                default: load_entry(5'(k), 16'($urandom), 16'($urandom));
            endcase
        end

        // Single-frame run under the reset register values, then a flip on a bit that both
        // classes call impossible, so that both likelihoods vanish and logs hit their floor.
        send_frame(32'd0, 1'b1);
        send_frame(32'h0000_0001, 1'b0);
        send_frame(32'h0000_0003, 1'b1);
        // A flip where only occlusion is possible, then one where only a match is, driving
        // the posterior to its ends; a table load in the middle of the run takes effect at once.
        send_frame(32'h0000_0004, 1'b0);
        send_frame(32'h0000_0008, 1'b0);
        load_entry(5'd5, 16'd1, 16'hFFFE);
        send_frame(32'hFFFF_FFF0, 1'b0);
        send_frame(32'h0000_0020, 1'b1);
        wait_quiet();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_STAY, 16'd0);
                    write_reg(CFG_ENTER, 16'd0);
                    write_reg(CFG_PRIOR_MATCH, 16'd0);
                    write_reg(CFG_PRIOR_OCC, 16'd0);
                end
                1: begin
                    write_reg(CFG_STAY, 16'hFFFF);
                    write_reg(CFG_ENTER, 16'hFFFF);
                    write_reg(CFG_PRIOR_MATCH, 16'hFFFF);
                    write_reg(CFG_PRIOR_OCC, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_STAY, 16'hFFFF);
                    write_reg(CFG_ENTER, 16'd0);
                    write_reg(CFG_PRIOR_MATCH, 16'hFFFF);
                    write_reg(CFG_PRIOR_OCC, 16'd0);
                end
                default: begin
                    write_reg(CFG_STAY, pick_prob());
                    write_reg(CFG_ENTER, pick_prob());
                    write_reg(CFG_PRIOR_MATCH, pick_prob());
                    write_reg(CFG_PRIOR_OCC, pick_prob());
                end
            endcase
            // One phase runs flat out on both sides; the others idle at random.
            idle_en = (phase != 4);
            if (phase == 5) hold_req = 1'b1;
            random_phase(240);
            wait_quiet();
        end

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
